// File: sv/bavg_pkg.sv
// Shared widths, register indexes and control bundles for the block average downsampler.
package bavg_pkg;

  localparam int PIX_W     = 16;
  localparam int COORD_W   = 12;
  localparam int SUM_W     = 24;
  localparam int DIM_W     = 13;
  localparam int BS_W      = 5;
  localparam int OFS_W     = 4;
  localparam int SQ_W      = 9;
  localparam int MEM_DEPTH = 4096;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int CFG_IDX_W = 2;
  localparam int MAX_BLOCK = 16;
  localparam int MAX_DIM   = 4096;
  localparam int DIV_CNT_W = $clog2(SUM_W);

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS = CFG_IDX_W'(2);

  localparam logic [BS_W-1:0]  RST_BLOCK_SIZE = BS_W'(2);
  localparam logic [DIM_W-1:0] RST_IMAGE_ROWS = DIM_W'(512);
  localparam logic [DIM_W-1:0] RST_IMAGE_COLS = DIM_W'(512);

  typedef struct packed {
    logic accept;
    logic acc;
    logic div_start;
    logic out_load;
  } bavg_cmd_t;

  typedef struct packed {
    logic emit;
  } bavg_sts_t;

endpackage

// File: sv/block_average_downsampler_core.sv
// Top level of the block average downsampler: controller, datapath and divider.
// Sequence: each beat is accepted in S_IDLE and then accumulated in S_ACC (memory read,
// then accumulate); in_stall stays high until the controller is back in S_IDLE, so a new
// beat is not taken before the last one is through. A beat that completes a block also holds
// the input through the serial divider and the result load, plus any output stall.
// Reset: synchronous, active low; clears scan position and control state and loads
// block_size 2, image 512 x 512; the block sum memory is overwritten at each block start.
module block_average_downsampler_core import bavg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_W-1:0]     in_pixel_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [COORD_W-1:0]   out_center_x,
  output logic [COORD_W-1:0]   out_center_y,
  output logic [PIX_W-1:0]     out_block_mean,
  output logic                 out_last_block
);

  bavg_cmd_t        cmd;
  bavg_sts_t        sts;
  logic             div_done;
  logic [SUM_W-1:0] div_quotient;
  logic [SUM_W-1:0] div_dividend;
  logic [SQ_W-1:0]  div_divisor;

  assign cfg_ready = 1'b1;

  bavg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .div_done  (div_done),
    .cmd       (cmd)
  );

  bavg_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_pixel_value (in_pixel_value),
    .cmd            (cmd),
    .sts            (sts),
    .div_quotient   (div_quotient),
    .div_dividend   (div_dividend),
    .div_divisor    (div_divisor),
    .out_center_x   (out_center_x),
    .out_center_y   (out_center_y),
    .out_block_mean (out_block_mean),
    .out_last_block (out_last_block)
  );

  bavg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

endmodule

// File: sv/bavg_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module bavg_div import bavg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [SQ_W-1:0]  divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  logic [SUM_W-1:0]     quo_r;
  logic [SQ_W-1:0]      rem_r;
  logic [SQ_W-1:0]      den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [SQ_W:0]        shifted;
  logic                 ge;
  logic [SQ_W-1:0]      rem_nxt;

  assign shifted = {rem_r, quo_r[SUM_W-1]};
  assign ge      = shifted >= {1'b0, den_r};
  assign rem_nxt = ge ? SQ_W'(shifted - {1'b0, den_r}) : SQ_W'(shifted);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      quo_r  <= dividend;
      rem_r  <= '0;
      den_r  <= divisor;
      cnt_r  <= '0;
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      quo_r <= {quo_r[SUM_W-2:0], ge};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(SUM_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: sv/bavg_dp.sv
// Datapath: configuration, scan counters, block sum memory and result registers.
module bavg_dp import bavg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic [PIX_W-1:0]     in_pixel_value,
  input  bavg_cmd_t            cmd,
  output bavg_sts_t            sts,
  input  logic [SUM_W-1:0]     div_quotient,
  output logic [SUM_W-1:0]     div_dividend,
  output logic [SQ_W-1:0]      div_divisor,
  output logic [COORD_W-1:0]   out_center_x,
  output logic [COORD_W-1:0]   out_center_y,
  output logic [PIX_W-1:0]     out_block_mean,
  output logic                 out_last_block
);

  logic [BS_W-1:0]  block_size_r;
  logic [DIM_W-1:0] image_rows_r;
  logic [DIM_W-1:0] image_cols_r;

  logic [DIM_W-1:0] y_pos_r, y_pos_nxt, x_pos_r, x_pos_nxt;
  logic [DIM_W-1:0] y0_r, y0_nxt, x0_r, x0_nxt;
  logic [DIM_W-1:0] brow_r, brow_nxt;
  logic [OFS_W-1:0] y_in_r, y_in_nxt, x_in_r, x_in_nxt;

  logic [SUM_W-1:0] sums_mem [MEM_DEPTH];
  logic [SUM_W-1:0] rd_r;
  logic [MEM_AW-1:0] addr_r;
  logic [PIX_W-1:0] px_r;
  logic             first_r, valid_r, emit_r, last_r, neg_r;
  logic [COORD_W-1:0] cx_r, cy_r;

  logic [COORD_W-1:0] center_x_r, center_y_r;
  logic [PIX_W-1:0]   mean_r;
  logic               last_block_r;

  logic [BS_W-1:0]  nk;
  logic [DIM_W-1:0] rows, cols;
  logic [OFS_W-1:0] half;
  logic [DIM_W:0]   y_end, x_end, y_end2, x_end2;
  logic             y_fit, x_fit, blk_valid, blk_first, blk_done, y_lastb, x_lastb;
  logic [DIM_W-1:0] y_inc, x_inc;
  logic [BS_W-1:0]  yin_inc, xin_inc;
  logic [SUM_W-1:0] sum_nxt;
  logic             restart;

  always_comb begin
    if (block_size_r == '0) begin
      nk = BS_W'(1);
    end else if (block_size_r > BS_W'(MAX_BLOCK)) begin
      nk = BS_W'(MAX_BLOCK);
    end else begin
      nk = block_size_r;
    end
    if (image_rows_r == '0) begin
      rows = DIM_W'(1);
    end else if (image_rows_r > DIM_W'(MAX_DIM)) begin
      rows = DIM_W'(MAX_DIM);
    end else begin
      rows = image_rows_r;
    end
    if (image_cols_r == '0) begin
      cols = DIM_W'(1);
    end else if (image_cols_r > DIM_W'(MAX_DIM)) begin
      cols = DIM_W'(MAX_DIM);
    end else begin
      cols = image_cols_r;
    end
  end

  assign half      = OFS_W'((nk - 1'b1) >> 1);
  assign y_end     = {1'b0, y0_r} + (DIM_W+1)'(nk);
  assign x_end     = {1'b0, x0_r} + (DIM_W+1)'(nk);
  assign y_end2    = y_end + (DIM_W+1)'(nk);
  assign x_end2    = x_end + (DIM_W+1)'(nk);
  assign y_fit     = y_end <= {1'b0, rows};
  assign x_fit     = x_end <= {1'b0, cols};
  assign y_lastb   = y_end2 > {1'b0, rows};
  assign x_lastb   = x_end2 > {1'b0, cols};
  assign blk_valid = y_fit && x_fit;
  assign blk_first = (y_in_r == '0) && (x_in_r == '0);
  assign yin_inc   = {1'b0, y_in_r} + 1'b1;
  assign xin_inc   = {1'b0, x_in_r} + 1'b1;
  assign blk_done  = (yin_inc == nk) && (xin_inc == nk);
  assign y_inc     = y_pos_r + 1'b1;
  assign x_inc     = x_pos_r + 1'b1;

  assign restart = cfg_wr && (cfg_index == CFG_BLOCK_SIZE || cfg_index == CFG_IMAGE_ROWS ||
                              cfg_index == CFG_IMAGE_COLS);

  always_comb begin
    y_pos_nxt = y_pos_r;
    x_pos_nxt = x_pos_r;
    y0_nxt    = y0_r;
    x0_nxt    = x0_r;
    brow_nxt  = brow_r;
    y_in_nxt  = y_in_r;
    x_in_nxt  = x_in_r;
    if (y_inc >= rows) begin
      y_pos_nxt = '0;
      y_in_nxt  = '0;
      y0_nxt    = '0;
      brow_nxt  = '0;
      if (x_inc >= cols) begin
        x_pos_nxt = '0;
        x_in_nxt  = '0;
        x0_nxt    = '0;
      end else begin
        x_pos_nxt = x_inc;
        if (xin_inc >= nk) begin
          x_in_nxt = '0;
          x0_nxt   = x0_r + DIM_W'(nk);
        end else begin
          x_in_nxt = xin_inc[OFS_W-1:0];
        end
      end
    end else begin
      y_pos_nxt = y_inc;
      if (yin_inc >= nk) begin
        y_in_nxt = '0;
        y0_nxt   = y0_r + DIM_W'(nk);
        brow_nxt = brow_r + 1'b1;
      end else begin
        y_in_nxt = yin_inc[OFS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r <= RST_BLOCK_SIZE;
      image_rows_r <= RST_IMAGE_ROWS;
      image_cols_r <= RST_IMAGE_COLS;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_BLOCK_SIZE: block_size_r <= cfg_data[BS_W-1:0];
        CFG_IMAGE_ROWS: image_rows_r <= cfg_data;
        CFG_IMAGE_COLS: image_cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      y_pos_r <= '0;
      x_pos_r <= '0;
      y0_r    <= '0;
      x0_r    <= '0;
      brow_r  <= '0;
      y_in_r  <= '0;
      x_in_r  <= '0;
    end else if (cmd.accept) begin
      y_pos_r <= y_pos_nxt;
      x_pos_r <= x_pos_nxt;
      y0_r    <= y0_nxt;
      x0_r    <= x0_nxt;
      brow_r  <= brow_nxt;
      y_in_r  <= y_in_nxt;
      x_in_r  <= x_in_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      emit_r  <= 1'b0;
    end else if (cmd.accept) begin
      valid_r <= blk_valid;
      emit_r  <= blk_valid && blk_done;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      px_r    <= in_pixel_value;
      first_r <= blk_first;
      addr_r  <= brow_r[MEM_AW-1:0];
      rd_r    <= sums_mem[brow_r[MEM_AW-1:0]];
      cx_r    <= COORD_W'(x0_r + DIM_W'(half));
      cy_r    <= COORD_W'(y0_r + DIM_W'(half));
      last_r  <= x_lastb && y_lastb;
    end
  end

  assign sum_nxt = first_r ? SUM_W'($signed(px_r))
                           : SUM_W'(rd_r + SUM_W'($signed(px_r)));

  always_ff @(posedge clk) begin
    if (cmd.acc && valid_r) begin
      sums_mem[addr_r] <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      neg_r <= sum_nxt[SUM_W-1];
    end
    if (cmd.out_load) begin
      center_x_r   <= cx_r;
      center_y_r   <= cy_r;
      mean_r       <= neg_r ? ~div_quotient[PIX_W-1:0] : div_quotient[PIX_W-1:0];
      last_block_r <= last_r;
    end
  end

  assign div_dividend   = sum_nxt[SUM_W-1] ? ~sum_nxt : sum_nxt;
  assign div_divisor    = SQ_W'(nk) * SQ_W'(nk);
  assign sts.emit       = emit_r;
  assign out_center_x   = center_x_r;
  assign out_center_y   = center_y_r;
  assign out_block_mean = mean_r;
  assign out_last_block = last_block_r;

endmodule

// File: sv/bavg_ctrl.sv
// Controller: sequences accept and accumulate per beat; divide and result load only for a beat that completes a block.
module bavg_ctrl import bavg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  bavg_sts_t sts,
  input  logic      div_done,
  output bavg_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACC,
    S_DIV
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd.accept    = (state_r == S_IDLE) && in_valid;
    cmd.acc       = (state_r == S_ACC);
    cmd.div_start = (state_r == S_ACC) && sts.emit;
    cmd.out_load  = (state_r == S_DIV) && div_done && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          state_r <= sts.emit ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          if (div_done && out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: tb/block_average_downsampler_core_tb.sv
// Testbench for the block average downsampler: streams images and checks every block beat.
module block_average_downsampler_core_tb;
  import bavg_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = CFG_IDX_W'(3);
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int MAX_REPORTS  = 10;

  typedef enum int {PIX_UNIFORM, PIX_RAILS, PIX_NEAR_ZERO} pix_style_t;

  typedef struct packed {
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic [PIX_W-1:0]   mean;
    logic               last;
  } block_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [PIX_W-1:0]     in_pixel_value;
  logic                 out_valid;
  logic                 out_stall;
  logic [COORD_W-1:0]   out_center_x;
  logic [COORD_W-1:0]   out_center_y;
  logic [PIX_W-1:0]     out_block_mean;
  logic                 out_last_block;

  block_average_downsampler_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_value (in_pixel_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_center_x   (out_center_x),
    .out_center_y   (out_center_y),
    .out_block_mean (out_block_mean),
    .out_last_block (out_last_block)
  );

  block_result_t   pending_blocks[$];
  int              blk_sum[MEM_DEPTH];
  int              scan_y, scan_x, ofs_y, ofs_x, blk_row, blk_col;
  logic [BS_W-1:0] size_reg;
  logic [DIM_W-1:0] rows_reg, cols_reg;
  int              sender_idle_pct = 0;
  int              receiver_idle_pct = 0;
  int              error_count = 0;
  int              cycle_count = 0;
  int              pixels_sent = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int eff_block_size();
    if (size_reg == 0) return 1;
    if (size_reg > MAX_BLOCK) return MAX_BLOCK;
    return int'(size_reg);
  endfunction

  function automatic int eff_extent(input logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(input pix_style_t style);
    case (style)
      PIX_RAILS:     return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      PIX_NEAR_ZERO: return PIX_W'(int'($urandom_range(6)) - 3);
      default:       return PIX_W'($urandom);
    endcase
  endfunction

  task automatic restart_scan();
    scan_y  = 0;
    scan_x  = 0;
    ofs_y   = 0;
    ofs_x   = 0;
    blk_row = 0;
    blk_col = 0;
  endtask

  task automatic block_average_step(input logic [PIX_W-1:0] v);
    int nk, rows, cols, half, s, q;
    block_result_t r;
    nk   = eff_block_size();
    rows = eff_extent(rows_reg);
    cols = eff_extent(cols_reg);
    if (blk_row < rows / nk && blk_col < cols / nk) begin
      if (ofs_x == 0 && ofs_y == 0) blk_sum[blk_row] = 0;
      s = blk_sum[blk_row] + int'($signed(v));
      blk_sum[blk_row] = s;
      if (ofs_x == nk - 1 && ofs_y == nk - 1) begin
        q = s / (nk * nk);
        if (s % (nk * nk) != 0 && s < 0) q--;
        half = (nk - 1) / 2;
        r.center_x = COORD_W'(blk_col * nk + half);
        r.center_y = COORD_W'(blk_row * nk + half);
        r.mean     = PIX_W'(q);
        r.last     = (blk_col == cols / nk - 1) && (blk_row == rows / nk - 1);
        pending_blocks.insert(pending_blocks.size(), r);
      end
    end
    // advance: y fastest, then x, wrap at image end
    scan_y++;
    ofs_y++;
    if (ofs_y >= nk) begin
      ofs_y = 0;
      blk_row++;
    end
    if (scan_y >= rows) begin
      scan_y  = 0;
      ofs_y   = 0;
      blk_row = 0;
      scan_x++;
      ofs_x++;
      if (ofs_x >= nk) begin
        ofs_x = 0;
        blk_col++;
      end
      if (scan_x >= cols) begin
        scan_x  = 0;
        ofs_x   = 0;
        blk_col = 0;
      end
    end
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] v);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      in_valid       <= 1'b0;
      in_pixel_value <= PIX_W'($urandom);
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_pixel_value <= v;
    do @(posedge clk); while (in_stall);
    block_average_step(v);
    pixels_sent++;
  endtask

  task automatic send_image(input pix_style_t style, input int count);
    repeat (count) send_pixel(pick_pixel(style));
  endtask

  task automatic send_constant(input logic [PIX_W-1:0] v, input int count);
    repeat (count) send_pixel(v);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_BLOCK_SIZE: size_reg = data[BS_W-1:0];
      CFG_IMAGE_ROWS: rows_reg = data;
      CFG_IMAGE_COLS: cols_reg = data;
      default: ;
    endcase
    if (idx == CFG_BLOCK_SIZE || idx == CFG_IMAGE_ROWS || idx == CFG_IMAGE_COLS) restart_scan();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [DIM_W-1:0] size_data, input logic [DIM_W-1:0] rows,
                           input logic [DIM_W-1:0] cols);
    write_reg(CFG_BLOCK_SIZE, size_data);
    write_reg(CFG_IMAGE_ROWS, rows);
    write_reg(CFG_IMAGE_COLS, cols);
  endtask

  task automatic test_reset_defaults();
    send_image(PIX_UNIFORM, int'(RST_IMAGE_ROWS) + 4);
  endtask

  task automatic test_single_pixel_blocks();
    logic [PIX_W-1:0] corner_pixels[7] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF,
                                           16'h0001, 16'h5555, 16'hAAAA};
    configure(1, 1, 1);
    foreach (corner_pixels[i]) send_pixel(corner_pixels[i]);
  endtask

  task automatic test_floor_mean();
    logic [PIX_W-1:0] column_pixels[6] = '{16'hFFFF, 16'h0000, 16'h0005,
                                           16'h0000, 16'h0000, 16'h0007};
    // drop the third row; the block sums to -1
    configure(2, 3, 2);
    foreach (column_pixels[i]) send_pixel(column_pixels[i]);
  endtask

  task automatic test_oversize_block();
    configure(3, 2, 2);
    send_image(PIX_UNIFORM, 4);
  endtask

  task automatic test_scan_restart();
    configure(2, 4, 2);
    send_image(PIX_UNIFORM, 3);
    write_reg(CFG_IMAGE_ROWS, 4);
    send_image(PIX_UNIFORM, 8);
  endtask

  task automatic test_register_clamps();
    configure(13'h1FFF, 16, 17);
    send_constant(16'h7FFF, 16 * 17);
    configure(16, 17, 16);
    send_constant(16'h8000, 17 * 16);
    configure(13'h1FE0, 0, 0);
    send_image(PIX_UNIFORM, 3);
  endtask

  task automatic test_extreme_dimensions();
    configure(1, 13'h1FFF, 1);
    send_image(PIX_UNIFORM, 32);
    configure(1, 0, DIM_W'(MAX_DIM));
    send_image(PIX_UNIFORM, 32);
  endtask

  task automatic run_random(input int count);
    int target, nk, rows, cols, pick, split;
    logic [BS_W-1:0]  bs;
    logic [DIM_W-1:0] size_data;
    pix_style_t       style;
    target = pixels_sent + count;
    while (pixels_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 70) bs = BS_W'($urandom_range(1, 4));
      else if (pick < 90) bs = BS_W'($urandom_range(5, 16));
      else if (pick < 95) bs = '0;
      else bs = BS_W'($urandom_range(17, 31));
      nk = (bs == 0) ? 1 : (bs > MAX_BLOCK) ? MAX_BLOCK : int'(bs);
      if (nk <= 4) begin
        rows = $urandom_range(nk, 2 * nk + 3);
        cols = $urandom_range(nk, 2 * nk + 3);
      end else begin
        rows = $urandom_range(nk, nk + 5);
        cols = $urandom_range(nk, nk + 3);
      end
      if ($urandom_range(9) == 0) rows = $urandom_range(1, nk);
      if ($urandom_range(9) == 0) cols = $urandom_range(1, nk);
      size_data = DIM_W'($urandom);
      size_data[BS_W-1:0] = bs;
      configure(size_data, DIM_W'(rows), DIM_W'(cols));
      if ($urandom_range(7) == 0) write_reg(CFG_SPARE_INDEX, DIM_W'($urandom));
      repeat ($urandom_range(1, 2)) begin
        pick  = $urandom_range(9);
        style = (pick < 6) ? PIX_UNIFORM : (pick < 8) ? PIX_RAILS : PIX_NEAR_ZERO;
        pick  = $urandom_range(9);
        if (pick < 2) begin
          send_image(style, $urandom_range(1, rows * cols));
        end else if (pick == 2) begin
          split = $urandom_range(0, rows * cols);
          send_image(style, split);
          write_reg(CFG_SPARE_INDEX, DIM_W'($urandom));
          send_image(style, rows * cols - split);
        end else begin
          send_image(style, rows * cols);
        end
      end
    end
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_idle_pct);
  end

  always @(posedge clk) begin : check_blocks
    block_result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_center_x, out_center_y, out_block_mean, out_last_block};
      if (pending_blocks.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected block beat: x=%0d y=%0d mean=%0d last=%0b",
                   got.center_x, got.center_y, $signed(got.mean), got.last);
      end else begin
        want = pending_blocks.pop_front();
        if (got !== want) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("mismatch: want x=%0d y=%0d m=%0d l=%0b got x=%0d y=%0d m=%0d l=%0b",
                     want.center_x, want.center_y, $signed(want.mean), want.last,
                     got.center_x, got.center_y, $signed(got.mean), got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[block_average_downsampler_core] ERROR");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_BLOCK_SIZE;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_pixel_value = '0;
    out_stall      = 1'b0;
    size_reg       = RST_BLOCK_SIZE;
    rows_reg       = RST_IMAGE_ROWS;
    cols_reg       = RST_IMAGE_COLS;
    foreach (blk_sum[i]) blk_sum[i] = 0;
    restart_scan();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    sender_idle_pct   = 34;
    receiver_idle_pct = 71;
    test_reset_defaults();
    test_single_pixel_blocks();
    test_floor_mean();
    test_oversize_block();
    test_scan_restart();
    run_random(50);

    sender_idle_pct   = 71;
    receiver_idle_pct = 34;
    test_register_clamps();
    run_random(50);

    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    run_random(50);
    test_extreme_dimensions();

    drain();
    if (error_count == 0) begin
      $display("[block_average_downsampler_core] OK");
    end else begin
      $display("[block_average_downsampler_core] ERROR");
    end
    $finish;
  end

endmodule
